@@ hdl/gn2d_pkg.sv @@
`timescale 1ns / 1ps

package gn2d_pkg;

  localparam int unsigned SineTableBitsDef = 10;
  localparam int unsigned CoordFracBitsDef = 16;

  localparam logic [31:0] HashMulA = 32'd3284157443;
  localparam logic [31:0] HashMulB = 32'd1911520717;
  localparam logic [31:0] HashMulC = 32'd2048419325;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] OneQ30    = 64'd1073741824;

  localparam int unsigned NoiseW    = 34;
  localparam int unsigned NumStages = 12;

  function automatic logic [31:0] rotl16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  // First quadrant of the sine table in Q1.14, evaluated at elaboration only.
  function automatic logic [14:0] sin_quarter(input int unsigned j, input int unsigned tbits);
    logic [63:0] th;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    th = (64'(j) * HalfPiQ30) >> (tbits - 2);
    x2 = (th * th) >> 30;
    t  = OneQ30;
    t  = OneQ30 - (((x2 * t) >> 30) / 64'd156);
    t  = OneQ30 - (((x2 * t) >> 30) / 64'd110);
    t  = OneQ30 - (((x2 * t) >> 30) / 64'd72);
    t  = OneQ30 - (((x2 * t) >> 30) / 64'd42);
    t  = OneQ30 - (((x2 * t) >> 30) / 64'd20);
    t  = OneQ30 - (((x2 * t) >> 30) / 64'd6);
    s  = (th * t) >> 30;
    return 15'((s + 64'd32768) >> 16);
  endfunction

endpackage

@@ hdl/gradient_noise_2d.sv @@
`timescale 1ns / 1ps

// Two-dimensional gradient noise generator.
// The request channel carries one point (x_coord_i, y_coord_i) in signed fixed
// point with COORD_FRAC_BITS fraction bits. A request is taken at a rising edge
// where in_valid_i is high and in_stall_o is low.
// The result channel returns one noise_value_o in signed Q2.14, saturated. It is
// taken at a rising edge where out_valid_o is high and out_stall_i is low.
// The datapath is a twelve-stage pipeline: a cell and fraction split, three hash
// multiply stages with the smoothstep weights beside them, a sine table read, the
// dot products, two blends with a multiply stage and an add stage each, and a
// rounding and saturation stage.
// Throughput is one point per cycle while the receiver does not stall. Each stage
// holds its item while the stage after it is full and stalled, so empty stages
// still fill when the receiver stalls. in_stall_o rises only when every stage
// holds an item. Reset clears all valid bits. No item survives reset, and no
// state is kept between items.
module gradient_noise_2d import gn2d_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = SineTableBitsDef,
  parameter int unsigned COORD_FRAC_BITS = CoordFracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] noise_value_o
);

  localparam int unsigned T   = SINE_TABLE_BITS;
  localparam int unsigned F   = COORD_FRAC_BITS;
  localparam int unsigned Q   = 1 << (T - 2);
  localparam int unsigned PW  = F + 17;
  localparam int unsigned XW  = F + 36;
  localparam int unsigned SHR = (F > 16) ? F - 16 : 0;
  localparam int unsigned SHL = (F < 16) ? 16 - F : 0;
  localparam int          RND = (F > 16) ? (1 << (F - 17)) : 0;
  localparam int unsigned MW  = NoiseW + F + 3;

  logic [14:0] qtab [Q+1];
  for (genvar j = 0; j <= Q; j++) begin : g_tab
    assign qtab[j] = sin_quarter(j, T);
  end

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // Stage 0: cell and fraction.
  logic [31:0]  cx_q, cy_q;
  logic [F-1:0] fx0_q, fy0_q;
  // Stage 1: first hash multiply and squared fractions.
  logic [31:0]  ax1_q [2];
  logic [31:0]  cy1_q [2];
  logic [F-1:0] fx1_q, fy1_q, t2x_q, t2y_q;
  // Stage 2: second hash multiply and weights.
  logic [31:0]  ax2_q [2];
  logic [31:0]  b2_q [4];
  logic [F-1:0] fx2_q, fy2_q;
  logic [F:0]   wx2_q, wy2_q;
  // Stage 3: table indexes.
  logic [T-1:0] k3_q [4];
  logic [F-1:0] fx3_q, fy3_q;
  logic [F:0]   wx3_q, wy3_q;
  // Stage 4: gradients.
  logic signed [15:0] gx4_q [4];
  logic signed [15:0] gy4_q [4];
  logic [F-1:0]       fx4_q, fy4_q;
  logic [F:0]         wx4_q, wy4_q;
  // Stage 5: dot product terms.
  logic signed [PW-1:0] px5_q [4];
  logic signed [PW-1:0] py5_q [4];
  logic [F:0]           wx5_q, wy5_q;
  // Stage 6: corner values in Q30.
  logic signed [NoiseW-1:0] n6_q [4];
  logic [F:0]               wx6_q, wy6_q;
  // Stages 7 to 10: blends; stage 11: rounded and saturated output.
  logic signed [MW-1:0]     pr7_q [2];
  logic signed [NoiseW-1:0] a7_q [2];
  logic [F:0]               wy7_q, wy8_q;
  logic signed [NoiseW-1:0] l8_q [2];
  logic signed [MW-1:0]     pv9_q;
  logic signed [NoiseW-1:0] l9_q;
  logic signed [NoiseW-1:0] v10_q;
  logic signed [15:0]       noise_q;

  logic [31:0]              cx_d, cy_d;
  logic [31:0]              ax1_d [2];
  logic [F-1:0]             t2x_d, t2y_d;
  logic [2*F-1:0]           sqx, sqy;
  logic [31:0]              b2_d [4];
  logic [F+1:0]             linx, liny;
  logic [2*F+1:0]           pwx, pwy;
  logic [F:0]               wx2_d, wy2_d;
  logic [31:0]              ah3 [4];
  logic [T-1:0]             k3_d [4];
  logic signed [15:0]       gx4_d [4];
  logic signed [15:0]       gy4_d [4];
  logic [1:0]               quad;
  logic [T-3:0]             rem;
  logic [T-2:0]             ridx, ridx_m;
  logic signed [F:0]        dx, dy;
  logic signed [PW-1:0]     px5_d [4];
  logic signed [PW-1:0]     py5_d [4];
  logic signed [XW-1:0]     dsum;
  logic signed [NoiseW-1:0] n6_d [4];
  logic signed [NoiseW:0]   diff7;
  logic signed [MW-1:0]     pr7_d [2];
  logic signed [MW-1:0]     sh8;
  logic signed [NoiseW-1:0] l8_d [2];
  logic signed [NoiseW:0]   diff9;
  logic signed [MW-1:0]     pv9_d;
  logic signed [MW-1:0]     sh10;
  logic signed [NoiseW:0]   r11;
  logic signed [15:0]       noise_d;

  always_comb begin
    cx_d = 32'(x_coord_i >>> F);
    cy_d = 32'(y_coord_i >>> F);

    ax1_d[0] = 32'(cx_q * HashMulA);
    ax1_d[1] = 32'((cx_q + 32'd1) * HashMulA);
    sqx      = fx0_q * fx0_q;
    sqy      = fy0_q * fy0_q;
    t2x_d    = sqx[2*F-1:F];
    t2y_d    = sqy[2*F-1:F];

    for (int c = 0; c < 4; c++) begin
      b2_d[c] = 32'((cy1_q[c/2] ^ rotl16(ax1_q[c%2])) * HashMulB);
    end
    linx  = (F+2)'(3) << F;
    linx  = linx - {1'b0, fx1_q, 1'b0};
    liny  = (F+2)'(3) << F;
    liny  = liny - {1'b0, fy1_q, 1'b0};
    pwx   = (2*F+2)'(t2x_q) * (2*F+2)'(linx);
    pwy   = (2*F+2)'(t2y_q) * (2*F+2)'(liny);
    wx2_d = pwx[2*F:F];
    wy2_d = pwy[2*F:F];

    for (int c = 0; c < 4; c++) begin
      ah3[c]  = 32'((ax2_q[c%2] ^ rotl16(b2_q[c])) * HashMulC);
      k3_d[c] = ah3[c][31 -: T];
    end

    quad   = '0;
    rem    = '0;
    ridx   = '0;
    ridx_m = '0;
    for (int c = 0; c < 4; c++) begin
      quad   = k3_q[c][T-1:T-2];
      rem    = k3_q[c][T-3:0];
      ridx   = {1'b0, rem};
      ridx_m = (T-1)'(Q) - ridx;
      case (quad)
        2'd0: begin
          gx4_d[c] = 16'(qtab[ridx]);
          gy4_d[c] = 16'(qtab[ridx_m]);
        end
        2'd1: begin
          gx4_d[c] = 16'(qtab[ridx_m]);
          gy4_d[c] = -16'(qtab[ridx]);
        end
        2'd2: begin
          gx4_d[c] = -16'(qtab[ridx]);
          gy4_d[c] = -16'(qtab[ridx_m]);
        end
        default: begin
          gx4_d[c] = -16'(qtab[ridx_m]);
          gy4_d[c] = 16'(qtab[ridx]);
        end
      endcase
    end

    dx = '0;
    dy = '0;
    for (int c = 0; c < 4; c++) begin
      dx       = $signed({1'(c % 2), fx4_q});
      dy       = $signed({1'(c / 2), fy4_q});
      px5_d[c] = PW'(dx) * PW'(gx4_q[c]);
      py5_d[c] = PW'(dy) * PW'(gy4_q[c]);
    end

    dsum = '0;
    for (int c = 0; c < 4; c++) begin
      dsum    = XW'(px5_q[c]) + XW'(py5_q[c]);
      dsum    = ((dsum + XW'(RND)) >>> SHR) <<< SHL;
      n6_d[c] = NoiseW'(dsum);
    end

    diff7 = '0;
    for (int i = 0; i < 2; i++) begin
      diff7    = (NoiseW+1)'(n6_q[2*i+1]) - (NoiseW+1)'(n6_q[2*i]);
      pr7_d[i] = MW'(diff7) * MW'($signed({1'b0, wx6_q}));
    end

    sh8 = '0;
    for (int i = 0; i < 2; i++) begin
      sh8     = pr7_q[i] >>> F;
      l8_d[i] = a7_q[i] + NoiseW'(sh8);
    end

    diff9 = (NoiseW+1)'(l8_q[1]) - (NoiseW+1)'(l8_q[0]);
    pv9_d = MW'(diff9) * MW'($signed({1'b0, wy8_q}));

    sh10 = pv9_q >>> F;

    r11 = ((NoiseW+1)'(v10_q) + (NoiseW+1)'(32768)) >>> 16;
    if (r11 > (NoiseW+1)'(32767)) begin
      noise_d = 16'sd32767;
    end else if (r11 < -(NoiseW+1)'(32768)) begin
      noise_d = -16'sd32768;
    end else begin
      noise_d = 16'(r11);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      cx_q  <= cx_d;
      cy_q  <= cy_d;
      fx0_q <= x_coord_i[F-1:0];
      fy0_q <= y_coord_i[F-1:0];
    end
    if (en[1]) begin
      ax1_q    <= ax1_d;
      cy1_q[0] <= cy_q;
      cy1_q[1] <= cy_q + 32'd1;
      fx1_q    <= fx0_q;
      fy1_q    <= fy0_q;
      t2x_q    <= t2x_d;
      t2y_q    <= t2y_d;
    end
    if (en[2]) begin
      ax2_q <= ax1_q;
      b2_q  <= b2_d;
      fx2_q <= fx1_q;
      fy2_q <= fy1_q;
      wx2_q <= wx2_d;
      wy2_q <= wy2_d;
    end
    if (en[3]) begin
      k3_q  <= k3_d;
      fx3_q <= fx2_q;
      fy3_q <= fy2_q;
      wx3_q <= wx2_q;
      wy3_q <= wy2_q;
    end
    if (en[4]) begin
      gx4_q <= gx4_d;
      gy4_q <= gy4_d;
      fx4_q <= fx3_q;
      fy4_q <= fy3_q;
      wx4_q <= wx3_q;
      wy4_q <= wy3_q;
    end
    if (en[5]) begin
      px5_q <= px5_d;
      py5_q <= py5_d;
      wx5_q <= wx4_q;
      wy5_q <= wy4_q;
    end
    if (en[6]) begin
      n6_q  <= n6_d;
      wx6_q <= wx5_q;
      wy6_q <= wy5_q;
    end
    if (en[7]) begin
      pr7_q   <= pr7_d;
      a7_q[0] <= n6_q[0];
      a7_q[1] <= n6_q[2];
      wy7_q   <= wy6_q;
    end
    if (en[8]) begin
      l8_q  <= l8_d;
      wy8_q <= wy7_q;
    end
    if (en[9]) begin
      pv9_q <= pv9_d;
      l9_q  <= l8_q[0];
    end
    if (en[10]) begin
      v10_q <= l9_q + NoiseW'(sh10);
    end
    if (en[11]) begin
      noise_q <= noise_d;
    end
  end

  assign noise_value_o = noise_q;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("Accepted request did not enter the first stage.");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q && out_stall_i))
    else $error("Input stalled while the pipeline had room.");

  a_last_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NumStages-2] && !(out_valid_o && out_stall_i)) |=> out_valid_o)
    else $error("Item in the last blend stage did not reach the output.");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import gn2d_pkg::*;

  localparam int unsigned TableBits = SineTableBitsDef;
  localparam int unsigned FracBits  = CoordFracBitsDef;
  localparam int unsigned Latency   = NumStages;
  localparam int          NumRandom = 1200;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               known;
    logic signed [15:0] noise;
  } point_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [31:0] x_coord_i;
  logic signed [31:0] y_coord_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] noise_value_o;

  logic signed [15:0] noise_queue[$];
  int                 error_count;
  logic               stimulus_done;
  logic               long_hold;

  gradient_noise_2d DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .x_coord_i,
    .y_coord_i,
    .out_valid_o,
    .out_stall_i,
    .noise_value_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint floor_div_pow2(longint v, int unsigned s);
    return v >>> s;
  endfunction

  function automatic logic [31:0] lattice_hash(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] a;
    logic [31:0] b;
    a = cx * 32'd3284157443;
    b = cy ^ {a[15:0], a[31:16]};
    b = b * 32'd1911520717;
    a = a ^ {b[15:0], b[31:16]};
    a = a * 32'd2048419325;
    return a >> (32 - TableBits);
  endfunction

  function automatic longint quarter_sine(longint unsigned j);
    longint unsigned th;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned divisors[6];
    divisors = '{156, 110, 72, 42, 20, 6};
    th = (j * 64'd1686629713) / ((64'd1 << TableBits) >> 2);
    x2 = (th * th) >> 30;
    t = 64'd1 << 30;
    for (int i = 0; i < 6; i++) t = (64'd1 << 30) - (((x2 * t) >> 30) / divisors[i]);
    return longint'((((th * t) >> 30) + 64'd32768) >> 16);
  endfunction

  function automatic longint table_sine(logic [31:0] k);
    longint unsigned n;
    longint unsigned q;
    longint unsigned kk;
    longint unsigned r;
    n = 64'd1 << TableBits;
    q = n >> 2;
    kk = k & (n - 1);
    r = kk % q;
    case (kk / q)
      0: return quarter_sine(r);
      1: return quarter_sine(q - r);
      2: return -quarter_sine(r);
      default: return -quarter_sine(q - r);
    endcase
  endfunction

  function automatic longint gradient_dot(logic [31:0] cx, logic [31:0] cy, longint dx,
                                          longint dy);
    logic [31:0] k;
    longint d;
    k = lattice_hash(cx, cy);
    d = dx * table_sine(k) + dy * table_sine(k + ((1 << TableBits) >> 2));
    if (FracBits > 16) return floor_div_pow2(d + (64'sd1 <<< (FracBits - 17)), FracBits - 16);
    if (FracBits < 16) return d * (64'sd1 <<< (16 - FracBits));
    return d;
  endfunction

  function automatic longint fade_weight(longint f);
    longint unsigned t2;
    t2 = (longint'(f) * f) >> FracBits;
    return longint'((t2 * longint'((64'sd3 <<< FracBits) - 2 * f)) >> FracBits);
  endfunction

  function automatic longint lerp(longint a, longint b, longint w);
    return a + floor_div_pow2((b - a) * w, FracBits);
  endfunction

  function automatic logic signed [15:0] noise_at(logic signed [31:0] x,
                                                  logic signed [31:0] y);
    logic [31:0] x0;
    logic [31:0] y0;
    longint fx;
    longint fy;
    longint one;
    longint wx;
    longint wy;
    longint v;
    longint r;
    one = 64'sd1 <<< FracBits;
    x0 = x >>> FracBits;
    y0 = y >>> FracBits;
    fx = longint'(x & ((32'd1 << FracBits) - 1));
    fy = longint'(y & ((32'd1 << FracBits) - 1));
    wx = fade_weight(fx);
    wy = fade_weight(fy);
    v = lerp(lerp(gradient_dot(x0, y0, fx, fy), gradient_dot(x0 + 1, y0, fx - one, fy), wx),
             lerp(gradient_dot(x0, y0 + 1, fx, fy - one),
                  gradient_dot(x0 + 1, y0 + 1, fx - one, fy - one), wx), wy);
    r = floor_div_pow2(v + 32768, 16);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic known, logic signed [15:0] noise);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_coord_i <= x;
    y_coord_i <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    noise_queue.push_back(known ? noise : noise_at(x, y));
  endtask

  initial begin
    point_row_t rows[16];
    logic signed [31:0] x;
    logic signed [31:0] y;
    rows = '{
      '{32'sd0, 32'sd0, 1'b1, 16'sd0},
      '{32'sh0001_0000, 32'sh0003_0000, 1'b1, 16'sd0},
      '{-32'sh0005_0000, 32'sh0007_0000, 1'b1, 16'sd0},
      '{32'sh8000_0000, 32'sh8000_0000, 1'b1, 16'sd0},
      '{32'sh7fff_0000, 32'sh7fff_0000, 1'b1, 16'sd0},
      '{32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0, 16'sd0},
      '{32'sh7fff_ffff, 32'sh8000_0000, 1'b0, 16'sd0},
      '{32'sh8000_0000, 32'sh7fff_ffff, 1'b0, 16'sd0},
      '{-32'sd1, -32'sd1, 1'b0, 16'sd0},
      '{32'sh0000_8000, 32'sh0000_8000, 1'b0, 16'sd0},
      '{-32'sh0000_8000, 32'sh0000_8000, 1'b0, 16'sd0},
      '{32'sh0000_ffff, 32'sd1, 1'b0, 16'sd0},
      '{32'sh1234_5678, -32'sh0abc_def0, 1'b0, 16'sd0},
      '{-32'sh0001_4000, -32'sh0002_c000, 1'b0, 16'sd0},
      '{32'sh5555_5555, 32'shaaaa_aaaa, 1'b0, 16'sd0},
      '{32'shaaaa_aaaa, 32'sh5555_5555, 1'b0, 16'sd0}
    };
    error_count = 0;
    stimulus_done = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    x_coord_i = '0;
    y_coord_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].known, rows[i].noise);
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 3) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (noise_queue.size() != 0) @(posedge clk_i);
      end
      case ($urandom_range(0, 3))
        0: begin
          x = $urandom();
          y = $urandom();
        end
        1: begin
          x = 32'($signed($urandom_range(0, 16'hffff)) - 32768) ^ {16'(0), 16'($urandom())};
          y = 32'($signed($urandom_range(0, 16'hffff)) - 32768) ^ {16'(0), 16'($urandom())};
          x = {{16{x[15]}}, 16'(0)} | 32'($urandom_range(0, 16'hffff));
          y = {{16{y[15]}}, 16'($urandom_range(0, 16'hffff))};
        end
        2: begin
          x = $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
          y = $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
        end
        default: begin
          x = ($urandom_range(0, 1) ? 32'h7fff_0000 : 32'h8000_0000) | $urandom_range(0, 16'hffff);
          y = $urandom();
        end
      endcase
      send_point(x, y, 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    stimulus_done = 1'b1;
  end

  initial begin
    int hold;
    long_hold = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (!long_hold && noise_queue.size() > 4) begin
        long_hold = 1'b1;
        hold = 60;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (noise_queue.size() == 0) begin
        $display("%0t: unexpected noise_value %0d", $time, noise_value_o);
        error_count++;
      end else begin
        if (noise_value_o !== noise_queue[0]) begin
          $display("%0t: noise_value expected %0d actual %0d", $time, noise_queue[0],
                   noise_value_o);
          error_count++;
        end
        void'(noise_queue.pop_front());
      end
    end
  end

  initial begin
    wait (stimulus_done);
    while (noise_queue.size() != 0) @(posedge clk_i);
    repeat (Latency * 3) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/gn2d_pkg.sv
hdl/gradient_noise_2d.sv
sim/testbench.sv
